>>> src/ritt_pkg.sv
`default_nettype none

package ritt_pkg;

  // Fixed field widths
  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;   // counts the WORD_W steps of one division
  localparam int BASE_W  = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 2;
  localparam int MAP_W   = 128;

  localparam logic [BASE_W-1:0] MIN_BASE = 5'd2;
  localparam logic [BASE_W-1:0] MAX_BASE = 5'd16;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2d;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_BASE_SIZE  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_CHARS_HIGH = 2'd2;

  localparam logic [BASE_W-1:0]  BASE_RESET       = 5'd10;
  localparam logic [WORD_W-1:0]  CHARS_LOW_RESET  = 64'd3978425819141910832;
  localparam logic [WORD_W-1:0]  CHARS_HIGH_RESET = 64'd7378413942531504440;

  // Microprogram steps
  typedef enum logic [2:0] {
    STEP_IDLE      = 3'd0,
    STEP_DIV_INIT  = 3'd1,
    STEP_DIV       = 3'd2,
    STEP_PUSH      = 3'd3,
    STEP_SIGN_TEST = 3'd4,
    STEP_SIGN      = 3'd5,
    STEP_READ      = 3'd6,
    STEP_DIGIT     = 3'd7
  } step_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DIV_CLEAR,
    ACT_DIV_STEP,
    ACT_PUSH,
    ACT_SIGN,
    ACT_READ,
    ACT_DIGIT
  } act_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_BITS_LEFT,
    COND_WORK_NZ,
    COND_NOT_NEG,
    COND_NOT_LAST
  } cond_t;

  typedef struct packed {
    wait_t wt;
    act_t  act;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Datapath command issued by the sequencer
  typedef struct packed {
    act_t act;
  } ctrl_t;

  // Datapath flags read by the sequencer
  typedef struct packed {
    logic out_free;
    logic bits_left;
    logic work_nz;
    logic neg;
    logic last_digit;
  } stat_t;

  // Control store: one word per step. A taken condition jumps to target,
  // otherwise the step counter advances (the last step wraps to idle).
  function automatic ucode_t ucode_fetch(step_t step);
    ucode_t w;
    unique case (step)
      STEP_IDLE:      w = '{WAIT_IN,   ACT_LOAD,      COND_NEVER,     STEP_IDLE};
      STEP_DIV_INIT:  w = '{WAIT_NONE, ACT_DIV_CLEAR, COND_NEVER,     STEP_IDLE};
      STEP_DIV:       w = '{WAIT_NONE, ACT_DIV_STEP,  COND_BITS_LEFT, STEP_DIV};
      STEP_PUSH:      w = '{WAIT_NONE, ACT_PUSH,      COND_WORK_NZ,   STEP_DIV_INIT};
      STEP_SIGN_TEST: w = '{WAIT_NONE, ACT_NONE,      COND_NOT_NEG,   STEP_READ};
      STEP_SIGN:      w = '{WAIT_OUT,  ACT_SIGN,      COND_NEVER,     STEP_IDLE};
      STEP_READ:      w = '{WAIT_NONE, ACT_READ,      COND_NEVER,     STEP_IDLE};
      STEP_DIGIT:     w = '{WAIT_OUT,  ACT_DIGIT,     COND_NOT_LAST,  STEP_READ};
      default:        w = '{WAIT_NONE, ACT_NONE,      COND_NEVER,     STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/ritt_if.sv
`default_nettype none

interface ritt_num_if;
  import ritt_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [WORD_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface ritt_text_if;
  import ritt_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  character;
  logic               last;
  logic [COUNT_W-1:0] char_count;

  modport source (output valid, output character, output last, output char_count,
                  input ready);
  modport sink   (input valid, input character, input last, input char_count,
                  output ready);
endinterface

interface ritt_cfg_if;
  import ritt_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  logic [WORD_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/radix_integer_to_text.sv
`default_nettype none

// Channel  Role    Payload                              Accepted when
// number   sink    mode, value                          number.valid & number.ready
// text     source  character, last, char_count          text.valid & text.ready
// cfg      sink    index, data                          cfg.valid & cfg.ready (always ready)
//
// Each digit comes from the 64 step shift-subtract divider, and the text sink may
// stall the output. One item is in work at a time.
// Reset (rst, synchronous) restores base 10 and the table "0123456789abcdef".
// A stalled text item holds in the output register; the next item is taken
// while the final character of the previous one still waits there.

module radix_integer_to_text
  import ritt_pkg::*;
#(
  parameter int MAX_DIGITS = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ritt_num_if.sink    number,
  ritt_text_if.source text,
  ritt_cfg_if.sink    cfg
);

  logic [BASE_W-1:0] base_size;
  logic [WORD_W-1:0] digit_chars_low;
  logic [WORD_W-1:0] digit_chars_high;
  logic [BASE_W-1:0] base;
  ctrl_t             ctrl;
  stat_t             stat;

  // Configuration registers: user writes only while idle, unenforced; unknown indexes drop
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_size        <= BASE_RESET;
      digit_chars_low  <= CHARS_LOW_RESET;
      digit_chars_high <= CHARS_HIGH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BASE_SIZE:  base_size        <= cfg.data[BASE_W-1:0];
        REG_CHARS_LOW:  digit_chars_low  <= cfg.data;
        REG_CHARS_HIGH: digit_chars_high <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Clamp the base into the supported range
  always_comb begin
    if (base_size < MIN_BASE) begin
      base = MIN_BASE;
    end else if (base_size > MAX_BASE) begin
      base = MAX_BASE;
    end else begin
      base = base_size;
    end
  end

  ritt_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (number.valid),
    .in_ready (number.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ritt_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .base      (base),
    .char_map  ({digit_chars_high, digit_chars_low}),
    .mode      (number.mode),
    .value     (number.value),
    .stat      (stat),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .out_char  (text.character),
    .out_last  (text.last),
    .out_count (text.char_count)
  );

`ifndef SYNTHESIS
  // Idle only after the final character of an item has been issued
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (number.ready && text.valid) |-> text.last)
    else $error("idle with a non-final character pending");

  // An accepted number starts a division at once
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (number.valid && number.ready) |=> !number.ready && !text.valid ||
                                       !number.ready && text.last)
    else $error("accepted number did not start conversion");
`endif

endmodule

`default_nettype wire

>>> src/ritt_sequencer.sv
`default_nettype none

module ritt_sequencer
  import ritt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  step_t  upc;
  step_t  upc_next;
  ucode_t word;
  logic   waiting;
  logic   taken;

  assign word = ucode_fetch(upc);

  always_comb begin
    waiting = ((word.wt == WAIT_IN) && !in_valid) ||
              ((word.wt == WAIT_OUT) && !stat.out_free);
  end

  always_comb begin
    unique case (word.cond)
      COND_NEVER:     taken = 1'b0;
      COND_BITS_LEFT: taken = stat.bits_left;
      COND_WORK_NZ:   taken = stat.work_nz;
      COND_NOT_NEG:   taken = !stat.neg;
      COND_NOT_LAST:  taken = !stat.last_digit;
      default:        taken = 1'b0;
    endcase
  end

  always_comb begin
    if (waiting) begin
      upc_next = upc;
    end else if (taken) begin
      upc_next = word.target;
    end else begin
      upc_next = step_t'(upc + 3'd1);
    end
  end

  assign in_ready = (word.wt == WAIT_IN);
  assign ctrl.act = waiting ? ACT_NONE : word.act;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

>>> src/ritt_datapath.sv
`default_nettype none

module ritt_datapath
  import ritt_pkg::*;
#(
  parameter int MAX_DIGITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_t              ctrl,
  input  wire logic [BASE_W-1:0]  base,
  input  wire logic [MAP_W-1:0]   char_map,
  input  wire logic               mode,
  input  wire logic [WORD_W-1:0]  value,
  output stat_t                   stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CHAR_W-1:0]       out_char,
  output logic                    out_last,
  output logic [COUNT_W-1:0]      out_count
);

  localparam int IDX_W   = $clog2(MAX_DIGITS);
  localparam int DEPTH_W = $clog2(MAX_DIGITS + 1);

  logic [WORD_W-1:0]  work;
  logic [DIGIT_W-1:0] rem;
  logic [BIT_W-1:0]   bitcnt;
  logic               neg;
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_m1;
  logic [COUNT_W-1:0] count;
  logic [DIGIT_W-1:0] rd_digit;
  logic [DIGIT_W-1:0] stack [MAX_DIGITS];

  logic [DIGIT_W:0]   trial;
  logic               fits;
  logic [31:0]        mag32;
  logic               emit;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem, work[WORD_W-1]};
  assign fits  = (trial >= base);
  assign mag32 = value[31] ? (32'd0 - value[31:0]) : value[31:0];

  assign depth_m1 = depth - DEPTH_W'(1);
  assign emit     = (ctrl.act == ACT_SIGN) || (ctrl.act == ACT_DIGIT);

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.bits_left  = (bitcnt != {BIT_W{1'b1}});
  assign stat.work_nz    = (work != '0);
  assign stat.neg        = neg;
  assign stat.last_digit = (depth == DEPTH_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      work   <= '0;
      rem    <= '0;
      bitcnt <= '0;
      neg    <= 1'b0;
      depth  <= '0;
      count  <= '0;
    end else begin
      case (ctrl.act)
        ACT_LOAD: begin
          neg   <= mode && value[31];
          work  <= mode ? {32'd0, mag32} : value;
          depth <= '0;
          count <= '0;
        end
        ACT_DIV_CLEAR: begin
          rem    <= '0;
          bitcnt <= '0;
        end
        ACT_DIV_STEP: begin
          rem    <= fits ? DIGIT_W'(trial - {1'b0, base}) : trial[DIGIT_W-1:0];
          work   <= {work[WORD_W-2:0], fits};
          bitcnt <= bitcnt + BIT_W'(1);
        end
        ACT_PUSH: begin
          // drop the excess digits once the stack is full
          if (depth < DEPTH_W'(MAX_DIGITS)) begin
            depth <= depth + DEPTH_W'(1);
          end
        end
        ACT_SIGN: begin
          count <= count + COUNT_W'(1);
        end
        ACT_DIGIT: begin
          count <= count + COUNT_W'(1);
          depth <= depth_m1;
        end
        default: begin
        end
      endcase
    end
  end

  // Digit stack
  always_ff @(posedge clk) begin
    if ((ctrl.act == ACT_PUSH) && (depth < DEPTH_W'(MAX_DIGITS))) begin
      stack[depth[IDX_W-1:0]] <= rem;
    end
    if (ctrl.act == ACT_READ) begin
      rd_digit <= stack[depth_m1[IDX_W-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_SIGN) begin
      out_char  <= MINUS_CHAR;
      out_last  <= 1'b0;
      out_count <= count + COUNT_W'(1);
    end else if (ctrl.act == ACT_DIGIT) begin
      out_char  <= char_map[{rd_digit, 3'b000} +: CHAR_W];
      out_last  <= (depth == DEPTH_W'(1));
      out_count <= count + COUNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(MAX_DIGITS))
    else $error("digit stack depth beyond capacity");

  a_digit_has_entry: assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_DIGIT) |-> (depth != '0))
    else $error("digit emitted from an empty stack");

  a_sign_before_digits: assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_SIGN) |-> (neg && (depth != '0) && (count == '0)))
    else $error("minus sign emitted out of place");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ritt_pkg::*;

  // Index with no register behind it; a write there must change nothing
  localparam logic [INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [WORD_W-1:0]  ALL_ONES  = {WORD_W{1'b1}};

  localparam int PLAN_LEN    = 23;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 32;

  // One character of converted text as it leaves the block
  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic [COUNT_W-1:0] count;
  } glyph_t;

  // Directed row: radix to set, the number, and its text when it is obvious
  // (right-justified, zero bytes ahead of it; all zero means "ask the predictor")
  typedef struct packed {
    logic [BASE_W-1:0] radix;
    logic              mode;
    logic [WORD_W-1:0] value;
    logic [8*20-1:0]   spelled;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{5'd10, 1'b0, 64'd0,                   "0"},
    '{5'd10, 1'b0, ALL_ONES,                "18446744073709551615"},
    '{5'd10, 1'b0, 64'd9,                   "9"},
    '{5'd10, 1'b0, 64'd10,                  "10"},
    '{5'd10, 1'b0, 64'h8000_0000_0000_0000, "9223372036854775808"},
    '{5'd10, 1'b1, 64'd0,                   "0"},
    '{5'd10, 1'b1, 64'h0000_0000_7FFF_FFFF, "2147483647"},
    '{5'd10, 1'b1, 64'h0000_0000_8000_0000, "-2147483648"},
    '{5'd10, 1'b1, ALL_ONES,                "-1"},
    '{5'd10, 1'b1, 64'hDEAD_BEEF_0000_0005, "5"},
    '{5'd10, 1'b1, 64'h0000_0000_FFFF_FF85, "-123"},
    '{5'd16, 1'b0, ALL_ONES,                "ffffffffffffffff"},
    '{5'd16, 1'b0, 64'h0123_4567_89AB_CDEF, "123456789abcdef"},
    '{5'd16, 1'b1, 64'hFFFF_FFFF_8000_0000, "-80000000"},
    '{5'd16, 1'b1, 64'h1234_5678_0000_00FF, "ff"},
    '{5'd2,  1'b0, ALL_ONES,                160'd0},
    '{5'd2,  1'b1, 64'h0000_0000_8000_0000, 160'd0},
    '{5'd2,  1'b0, 64'd1,                   "1"},
    '{5'd0,  1'b0, 64'd5,                   "101"},
    '{5'd1,  1'b1, 64'h0000_0000_FFFF_FFFE, "-10"},
    '{5'd31, 1'b0, 64'd255,                 "ff"},
    '{5'd17, 1'b0, ALL_ONES,                "ffffffffffffffff"},
    '{5'd17, 1'b0, 64'd0,                   "0"}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  ritt_num_if  number_ch ();
  ritt_text_if text_ch ();
  ritt_cfg_if  cfg_ch ();

  radix_integer_to_text uut (
    .clk    (clk),
    .rst    (rst),
    .number (number_ch),
    .text   (text_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Our copy of the registers; they only change while the block is idle
  logic [BASE_W-1:0] cur_radix     = BASE_RESET;
  logic [WORD_W-1:0] cur_digits_lo = CHARS_LOW_RESET;
  logic [WORD_W-1:0] cur_digits_hi = CHARS_HIGH_RESET;

  // Characters still owed by the block, oldest first
  glyph_t queued_glyphs [$];

  int mismatches    = 0;
  int numbers_sent  = 0;
  int negatives     = 0;
  int glyphs_seen   = 0;
  int reg_writes    = 0;
  int gap_pct       = 30;   // chance per item that the sender idles first
  int stall_pct     = 20;   // chance per cycle that the text side starts a stall

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Mostly short gaps, some medium, a rare long one
  function automatic int pick_gap(input int pct);
    int r;
    if ($urandom_range(0, 99) >= pct)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(1, 3);
    if (r < 95)
      return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // Work out the text of one number under the current registers and queue it
  function automatic void spell_number(input logic m, input logic [WORD_W-1:0] raw);
    logic [BASE_W-1:0]  radix;
    logic [WORD_W-1:0]  mag;
    logic [MAP_W-1:0]   map;
    logic [DIGIT_W-1:0] digits [$];
    logic               neg;
    glyph_t             g;
    radix = cur_radix;
    if (radix < MIN_BASE)
      radix = MIN_BASE;
    if (radix > MAX_BASE)
      radix = MAX_BASE;
    map = {cur_digits_hi, cur_digits_lo};
    // Signed mode looks at the low word only; negate it in 32 bits so the
    // most negative value keeps its exact magnitude
    neg = m && raw[31];
    if (!m)
      mag = raw;
    else if (neg)
      mag = {32'd0, ~raw[31:0] + 32'd1};
    else
      mag = {32'd0, raw[31:0]};
    // Collect digits least significant first; zero still yields one digit
    do begin
      digits.push_back(DIGIT_W'(mag % WORD_W'(radix)));
      mag = mag / WORD_W'(radix);
    end while (mag != '0);
    if (neg) begin
      g.character = MINUS_CHAR;
      g.last      = 1'b0;
      g.count     = COUNT_W'(1);
      queued_glyphs.push_back(g);
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      g.character = map[CHAR_W*int'(digits[i]) +: CHAR_W];
      g.last      = (i == 0);
      g.count     = COUNT_W'(digits.size() - i + (neg ? 1 : 0));
      queued_glyphs.push_back(g);
    end
  endfunction

  // Queue a text typed into the directed table
  function automatic void expect_spelled(input logic [8*20-1:0] s);
    glyph_t g;
    int     top;
    top = 19;
    while (top >= 0 && s[8*top +: 8] == 8'd0)
      top--;
    for (int i = top; i >= 0; i--) begin
      g.character = s[8*i +: 8];
      g.last      = (i == 0);
      g.count     = COUNT_W'(top - i + 1);
      queued_glyphs.push_back(g);
    end
  endfunction

  // Random number: many small magnitudes so that most texts stay short,
  // plus full-width patterns and the corner values
  function automatic logic [WORD_W-1:0] draw_value(input logic m);
    logic [WORD_W-1:0] v;
    logic [31:0]       low;
    int                w;
    int                pick;
    v    = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    w    = $urandom_range(1, 64);
    if (pick < 4) begin
      v = '0;
    end else if (pick < 8) begin
      v = ALL_ONES;
    end else if (pick < 12) begin
      v[31:0] = 32'h8000_0000;
    end else if (pick < 60) begin
      if (!m) begin
        v = v & (ALL_ONES >> (WORD_W - w));
      end else begin
        low     = v[31:0] & (32'hFFFF_FFFF >> (32 - (w + 1) / 2));
        v[31:0] = $urandom_range(0, 1) ? low : -low;
      end
    end
    return v;
  endfunction

  // Compare one accepted character with the oldest one owed
  task automatic check_glyph();
    glyph_t want;
    glyphs_seen++;
    if (queued_glyphs.size() == 0) begin
      flag_mismatch($sformatf("character 8'h%02h arrived with nothing owed",
                              text_ch.character));
      return;
    end
    want = queued_glyphs.pop_front();
    if (text_ch.character !== want.character)
      flag_mismatch($sformatf("character 8'h%02h, wanted 8'h%02h (count %0d)",
                              text_ch.character, want.character, want.count));
    if (text_ch.last !== want.last)
      flag_mismatch($sformatf("last %b, wanted %b (count %0d)",
                              text_ch.last, want.last, want.count));
    if (text_ch.char_count !== want.count)
      flag_mismatch($sformatf("char_count %0d, wanted %0d",
                              text_ch.char_count, want.count));
  endtask

  // Present one number after a random gap and hold until it is taken.
  // Leave valid high so a gapless next item follows without a bubble.
  task automatic offer(input logic m, input logic [WORD_W-1:0] v);
    int gap;
    gap = pick_gap(gap_pct);
    if (gap > 0) begin
      number_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    number_ch.valid <= 1'b1;
    number_ch.mode  <= m;
    number_ch.value <= v;
    do @(posedge clk); while (!number_ch.ready);
    numbers_sent++;
    if (m && v[31])
      negatives++;
  endtask

  // Drop valid and wait until every owed character has come out
  task automatic settle();
    number_ch.valid <= 1'b0;
    while (queued_glyphs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; the caller drops valid after the last write
  task automatic cfg_write(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    reg_writes++;
    case (idx)
      REG_BASE_SIZE:  cur_radix     = data[BASE_W-1:0];
      REG_CHARS_LOW:  cur_digits_lo = data;
      REG_CHARS_HIGH: cur_digits_hi = data;
      default: ;
    endcase
  endtask

  // Text side: take characters, stalling in random bursts
  initial begin : text_sink
    int hold;
    hold = 0;
    text_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && text_ch.valid && text_ch.ready)
        check_glyph();
      if (hold == 0)
        hold = pick_gap(stall_pct);
      if (hold > 0) begin
        hold--;
        text_ch.ready <= 1'b0;
      end else begin
        text_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic              m;
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [BASE_W-1:0] radix;
    number_ch.valid <= 1'b0;
    number_ch.mode  <= 1'b0;
    number_ch.value <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_BASE_SIZE;
    cfg_ch.data     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table: switch radix only with the block drained
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (PLAN[r].radix != cur_radix) begin
        settle();
        cfg_write(REG_BASE_SIZE, WORD_W'(PLAN[r].radix));
        cfg_ch.valid <= 1'b0;
      end
      offer(PLAN[r].mode, PLAN[r].value);
      if (PLAN[r].spelled != '0)
        expect_spelled(PLAN[r].spelled);
      else
        spell_number(PLAN[r].mode, PLAN[r].value);
    end

    // Random phases, each under its own radix and digit table
    for (int p = 0; p < PHASES; p++) begin
      settle();
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (p)
        0: radix = 5'd2;
        1: begin
          // table extremes: all zero bytes low, all 0xff bytes high
          radix = 5'd16;
          lo    = '0;
          hi    = ALL_ONES;
        end
        2: begin
          radix = BASE_W'($urandom_range(3, 15));
          lo    = CHARS_LOW_RESET;
          hi    = CHARS_HIGH_RESET;
        end
        3: radix = 5'd31;
        4: begin
          radix = 5'd1;
          hi    = CHARS_HIGH_RESET;
        end
        default: radix = BASE_W'($urandom_range(0, 31));
      endcase
      cfg_write(REG_BASE_SIZE, WORD_W'(radix));
      cfg_write(REG_CHARS_LOW, lo);
      cfg_write(REG_CHARS_HIGH, hi);
      // poke the unused index; predictions must stay as they are
      if (p == 3)
        cfg_write(REG_SPARE, {$urandom, $urandom});
      cfg_ch.valid <= 1'b0;

      // one phase runs flat out, one idles heavily, the rest in between
      gap_pct   = (p == 2) ? 0 : (p == 4) ? 60 : 30;
      stall_pct = (p == 2) ? 0 : (p == 4) ? 40 : 20;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // in even phases, hold the sender mid-phase until the text side has caught up
        if (k == PHASE_ITEMS / 2 && p % 2 == 0)
          settle();
        m = 1'($urandom_range(0, 1));
        v = draw_value(m);
        offer(m, v);
        spell_number(m, v);
      end
    end

    settle();
    repeat (16) @(posedge clk);

    $display("Converted %0d numbers (%0d negative) over %0d register writes,",
             numbers_sent, negatives, reg_writes);
    $display("radix 2 to 16 with clamped settings and varied digit tables; %0d characters",
             glyphs_seen);
    if (mismatches == 0) begin
      $display("** radix_integer_to_text: PASSED **");
    end else begin
      $display("** radix_integer_to_text: FAILED **");
    end
    $finish;
  end

  // Give up if the block wedges
  initial begin : watchdog
    #40_000_000;
    $display("** radix_integer_to_text: FAILED **");
    $finish;
  end

endmodule
